>>> hdl/pba_pkg.sv
// shared types and constants of the page bitmap allocator
`default_nettype none

package pba_pkg;

	localparam int MAP_BITS = 8;
	localparam int BIT_W    = 3;
	localparam int PAGE_W   = 16;
	localparam int COUNT_W  = 11;
	localparam int LIMIT_W  = 17;

	localparam logic [1:0] FUNC_CLAIM = 2'd0;
	localparam logic [1:0] FUNC_GET   = 2'd1;
	localparam logic [1:0] FUNC_FREE  = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [PAGE_W-1:0]  page_index;
		logic [COUNT_W-1:0] page_count;
	} cmd_t;

	typedef struct packed {
		logic               ok;
		logic [PAGE_W-1:0]  found_page;
		logic [LIMIT_W-1:0] free_pages;
	} rsp_t;

	// one map row and the page window inside it
	typedef struct packed {
		logic [MAP_BITS-1:0] data;
		logic [BIT_W-1:0]    lo;
		logic [BIT_W:0]      hi;
	} row_req_t;

	typedef struct packed {
		logic [MAP_BITS-1:0] mask;
		logic                any_used;
		logic [BIT_W-1:0]    first_used;
		logic [BIT_W:0]      used_cnt;
	} row_res_t;

endpackage

`default_nettype wire

>>> hdl/pba_map_ram.sv
// page bitmap storage, one write port and one registered read port
`default_nettype none

module pba_map_ram #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [ADDR_W-1:0]            wr_addr,
	input  wire logic [pba_pkg::MAP_BITS-1:0] wr_data,
	input  wire logic [ADDR_W-1:0]            rd_addr,
	output logic      [pba_pkg::MAP_BITS-1:0] rd_data
);

	logic [pba_pkg::MAP_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> hdl/pba_row_unit.sv
// shared row unit: window mask, first used page and count of used pages in one row
`default_nettype none

module pba_row_unit (
	input  wire pba_pkg::row_req_t req,
	output pba_pkg::row_res_t      res
);

	logic [pba_pkg::MAP_BITS-1:0] mask;
	logic [pba_pkg::MAP_BITS-1:0] used;
	logic [pba_pkg::BIT_W-1:0]    first;
	logic [pba_pkg::BIT_W:0]      cnt;

	always_comb begin
		for (int i = 0; i < pba_pkg::MAP_BITS; i++) begin
			mask[i] = ((pba_pkg::BIT_W+1)'(i) >= {1'b0, req.lo}) &&
				((pba_pkg::BIT_W+1)'(i) < req.hi);
		end
		used = ~req.data & mask;
	end

	// lowest used page wins
	always_comb begin
		first = '0;
		for (int i = pba_pkg::MAP_BITS - 1; i >= 0; i--) begin
			if (used[i]) begin
				first = pba_pkg::BIT_W'(i);
			end
		end
	end

	always_comb begin
		cnt = '0;
		for (int i = 0; i < pba_pkg::MAP_BITS; i++) begin
			cnt = cnt + (pba_pkg::BIT_W+1)'(used[i]);
		end
	end

	assign res.mask       = mask;
	assign res.any_used   = |used;
	assign res.first_used = first;
	assign res.used_cnt   = cnt;

endmodule

`default_nettype wire

>>> hdl/page_bitmap_allocator.sv
// page bitmap allocator top level: sequencer, limit register and counters
//
//   channel   signals                          handshake
//   command   start, busy, cmd                 taken when start & !busy
//   result    done, rsp                        one-cycle strobe, always taken
//   config    cfg_valid, cfg_ready, cfg_data   taken when valid & ready
//
// each map row touched takes a read step, then a check and write-back step; a run of n
// pages spans up to ceil(n/8)+1 rows, and a free walks those rows once after its beat
// a claim walks its run twice (check, then take); a get adds a start step per start page
// tried and restarts past each used page; trivial commands answer straight from idle
// after reset a clearing pass writes all ceil(min(NUM_PAGES,65536)/8) rows with busy
// high, config writes are taken meanwhile; done strobes each result, no stalls
`default_nettype none

module page_bitmap_allocator #(
	parameter int NUM_PAGES = 65536,
	parameter int MAX_RUN   = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire pba_pkg::cmd_t                 cmd,
	output logic                               done,
	output pba_pkg::rsp_t                      rsp,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pba_pkg::LIMIT_W-1:0]   cfg_data
);

	localparam int MAP_PAGES = (NUM_PAGES > 65536) ? 65536 : NUM_PAGES;
	localparam int ROWS      = (MAP_PAGES + pba_pkg::MAP_BITS - 1) / pba_pkg::MAP_BITS;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LW        = pba_pkg::LIMIT_W;
	localparam int BW        = pba_pkg::BIT_W;
	localparam int RW        = LW - BW;
	localparam logic [LW-1:0]    MAP_LIM  = LW'(MAP_PAGES);
	localparam logic [LW-1:0]    RUN_MAX  = LW'(MAX_RUN);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_RD,
		ST_CHK
	} state_t;

	typedef enum logic [1:0] {
		MODE_CHECK,
		MODE_TAKE,
		MODE_FREE
	} mode_t;

	state_t                        state_q;
	mode_t                         mode_q;
	logic [1:0]                    func_q;
	logic                          pass_q;
	logic [LW-1:0]                 cur_q;
	logic [LW-1:0]                 end_q;
	logic [LW-1:0]                 s_q;
	logic [LW-1:0]                 n_q;
	logic [LW-1:0]                 lim_q;
	logic [pba_pkg::PAGE_W-1:0]    hint_q;
	logic [LW-1:0]                 count_q;
	logic [LW-1:0]                 page_limit_q;
	logic [ROW_W-1:0]              clr_q;
	logic                          done_q;
	pba_pkg::rsp_t                 rsp_q;

	logic [pba_pkg::MAP_BITS-1:0]  rd_data;
	logic                          wr_en;
	logic [ROW_W-1:0]              wr_addr;
	logic [pba_pkg::MAP_BITS-1:0]  wr_data;
	logic [ROW_W-1:0]              rd_addr;

	pba_pkg::row_req_t             ru_req;
	pba_pkg::row_res_t             ru_res;

	logic [RW-1:0]                 cur_row;
	logic                          same_row;
	logic [LW-1:0]                 next_page;
	logic                          last_row;
	logic [LW-1:0]                 used_next;
	logic [LW-1:0]                 cnt_add;
	logic [LW-1:0]                 eff_lim;
	logic [LW-1:0]                 in_n;
	logic [LW-1:0]                 in_idx;
	logic [LW-1:0]                 in_end;
	logic [LW-1:0]                 free_end;
	logic [LW-1:0]                 s_end;
	logic                          accept;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign eff_lim  = (page_limit_q < MAP_LIM) ? page_limit_q : MAP_LIM;
	assign in_n     = LW'(cmd.page_count);
	assign in_idx   = LW'(cmd.page_index);
	assign in_end   = in_idx + in_n;
	assign free_end = (in_end < eff_lim) ? in_end : eff_lim;
	assign s_end    = s_q + n_q;

	// window of the current row that lies inside the run
	assign cur_row   = cur_q[LW-1:BW];
	assign same_row  = (cur_row == end_q[LW-1:BW]);
	assign next_page = same_row ? end_q : {cur_row + RW'(1), BW'(0)};
	assign last_row  = (next_page >= end_q);
	assign used_next = {cur_row, ru_res.first_used} + LW'(1);
	assign cnt_add   = count_q + LW'(ru_res.used_cnt);

	assign ru_req.data = rd_data;
	assign ru_req.lo   = cur_q[BW-1:0];
	assign ru_req.hi   = same_row ? {1'b0, end_q[BW-1:0]} : (BW+1)'(pba_pkg::MAP_BITS);

	pba_row_unit u_row (
		.req (ru_req),
		.res (ru_res)
	);

	assign rd_addr = cur_q[BW +: ROW_W];
	assign wr_en   = (state_q == ST_CLEAR) || ((state_q == ST_CHK) && (mode_q != MODE_CHECK));
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : cur_q[BW +: ROW_W];
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_data = '0;
		end else if (mode_q == MODE_TAKE) begin
			wr_data = rd_data & ~ru_res.mask;
		end else begin
			wr_data = rd_data | ru_res.mask;
		end
	end

	pba_map_ram #(
		.DEPTH  (ROWS),
		.ADDR_W (ROW_W)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			mode_q       <= MODE_CHECK;
			func_q       <= pba_pkg::FUNC_CLAIM;
			pass_q       <= 1'b0;
			hint_q       <= '0;
			count_q      <= '0;
			page_limit_q <= LW'(65536);
			clr_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				page_limit_q <= cfg_data;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						func_q <= cmd.func;
						n_q    <= in_n;
						lim_q  <= eff_lim;
						rsp_q  <= '{ok: 1'b0, found_page: '0, free_pages: count_q};
						case (cmd.func)
							pba_pkg::FUNC_CLAIM: begin
								if (in_n == '0) begin
									rsp_q.ok <= 1'b1;
									done_q   <= 1'b1;
								end else if (in_n > RUN_MAX || in_end > eff_lim) begin
									done_q <= 1'b1;
								end else begin
									s_q     <= in_idx;
									cur_q   <= in_idx;
									end_q   <= in_end;
									mode_q  <= MODE_CHECK;
									state_q <= ST_RD;
								end
							end
							pba_pkg::FUNC_GET: begin
								if (in_n == '0) begin
									rsp_q.ok <= 1'b1;
									done_q   <= 1'b1;
								end else if (in_n > RUN_MAX) begin
									done_q <= 1'b1;
								end else begin
									s_q     <= LW'(hint_q);
									pass_q  <= 1'b0;
									state_q <= ST_START;
								end
							end
							pba_pkg::FUNC_FREE: begin
								rsp_q.ok <= 1'b1;
								if (in_n == '0 || in_n > RUN_MAX || in_idx >= eff_lim) begin
									done_q <= 1'b1;
								end else begin
									cur_q   <= in_idx;
									end_q   <= free_end;
									mode_q  <= MODE_FREE;
									state_q <= ST_RD;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_START: begin
					// try the start page in s_q, wrap to zero after the first pass
					if (!pass_q) begin
						if (s_end <= lim_q) begin
							cur_q   <= s_q;
							end_q   <= s_end;
							mode_q  <= MODE_CHECK;
							state_q <= ST_RD;
						end else begin
							pass_q <= 1'b1;
							s_q    <= '0;
						end
					end else if (s_q < LW'(hint_q) && s_end <= lim_q) begin
						cur_q   <= s_q;
						end_q   <= s_end;
						mode_q  <= MODE_CHECK;
						state_q <= ST_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					cur_q   <= next_page;
					state_q <= ST_RD;
					unique case (mode_q)
						MODE_CHECK: begin
							if (ru_res.any_used) begin
								if (func_q == pba_pkg::FUNC_GET) begin
									s_q     <= used_next;
									state_q <= ST_START;
								end else begin
									done_q  <= 1'b1;
									state_q <= ST_IDLE;
								end
							end else if (last_row) begin
								cur_q  <= s_q;
								mode_q <= MODE_TAKE;
							end
						end
						MODE_TAKE: begin
							if (last_row) begin
								count_q          <= count_q - n_q;
								rsp_q.ok         <= 1'b1;
								rsp_q.free_pages <= count_q - n_q;
								if (func_q == pba_pkg::FUNC_GET) begin
									hint_q           <= s_end[pba_pkg::PAGE_W-1:0] -
										pba_pkg::PAGE_W'(1);
									rsp_q.found_page <= s_q[pba_pkg::PAGE_W-1:0];
								end
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						MODE_FREE: begin
							count_q <= cnt_add;
							if (last_row) begin
								rsp_q.free_pages <= cnt_add;
								done_q           <= 1'b1;
								state_q          <= ST_IDLE;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// a run being taken was checked free beforehand
	a_take_all_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK && mode_q == MODE_TAKE) |-> !ru_res.any_used)
		else $error("taking a run that holds a used page");

	// a row read always lies inside the run
	a_cur_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (cur_q < end_q))
		else $error("row walk outside the run");

	// the map is written only by the clearing pass or while taking or freeing
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_START || state_q == ST_RD) |-> !wr_en)
		else $error("map written outside a write step");

	// a found page is reported only with success
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.found_page != '0) |-> rsp.ok)
		else $error("found page without success");

	// every result beat lands back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_IDLE))
		else $error("result beat while still working");
`endif

endmodule

`default_nettype wire
